// ----- rtl/idea_block_cipher_core_macros.svh -----
// assertion macros for the idea block cipher core
`ifndef IDEA_BLOCK_CIPHER_CORE_MACROS_SVH
`define IDEA_BLOCK_CIPHER_CORE_MACROS_SVH

`ifndef SYNTH
`define IBC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define IBC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define IBC_ASSERT_IMP(lbl, ante, cons)
`define IBC_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

// ----- rtl/ibc_pkg.sv -----
// shared constants, types and the mod 65537 multiply for the idea block cipher core
package ibc_pkg;

  localparam int ROUNDS     = 8;
  localparam int KEY_DEPTH  = 6 * ROUNDS + 4;
  localparam int KEY_AW     = $clog2(KEY_DEPTH);
  localparam int RND_W      = (ROUNDS > 1) ? $clog2(ROUNDS) : 1;
  localparam int STEP_W     = 3;
  localparam int WORD_W     = 16;
  localparam int BLOCK_W    = 64;
  localparam int IN_TDATA_W = 88;

  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_BLOCK = 1'b1;

  localparam logic [STEP_W-1:0] STEP_MUL0 = 3'd0;
  localparam logic [STEP_W-1:0] STEP_ADD1 = 3'd1;
  localparam logic [STEP_W-1:0] STEP_ADD2 = 3'd2;
  localparam logic [STEP_W-1:0] STEP_MUL3 = 3'd3;
  localparam logic [STEP_W-1:0] STEP_MULT = 3'd4;
  localparam logic [STEP_W-1:0] STEP_MULU = 3'd5;
  localparam logic [STEP_W-1:0] STEP_MIX  = 3'd6;

  localparam logic [STEP_W-1:0] FIN_MUL0 = 3'd0;
  localparam logic [STEP_W-1:0] FIN_ADD1 = 3'd1;
  localparam logic [STEP_W-1:0] FIN_ADD2 = 3'd2;
  localparam logic [STEP_W-1:0] FIN_MUL3 = 3'd3;

  typedef logic [WORD_W-1:0] word_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ROUND,
    ST_FINAL,
    ST_OUT
  } state_t;

  // zero operand stands for 65536
  function automatic word_t mulmod(word_t a, word_t b);
    logic [2*WORD_W-1:0] p;
    word_t lo;
    word_t hi;
    word_t res;
    p  = {{WORD_W{1'b0}}, a} * {{WORD_W{1'b0}}, b};
    lo = p[WORD_W-1:0];
    hi = p[2*WORD_W-1:WORD_W];
    if (a == '0) begin
      res = word_t'(1) - b;
    end else if (b == '0) begin
      res = word_t'(1) - a;
    end else begin
      res = lo - hi + {{(WORD_W-1){1'b0}}, (hi > lo)};
    end
    return res;
  endfunction

endpackage

// ----- rtl/ibc_ram.sv -----
// generic single write port ram with registered read
module ibc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 52
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/idea_block_cipher_core.sv -----
// idea block cipher core: subkey store, shared round unit and sequencer
//
// channel  dir  handshake             payload
// in       in   in_tvalid/in_tready   tuser req_type, tdata key fields and block
// out      out  out_tvalid/out_tready tdata block_out
//
// load transaction: written straight into the subkey store if key_index < 52
// block transaction: round steps mul0, add1, add2, mul3, mult, mulu, mix for each
//   of ROUNDS rounds, transform steps mul0, add1, add2, mul3, then the output register;
//   subkeys read in turn from the single read port store, one shared mod 65537 multiplier
// reset clears control state only; the subkey store holds nothing until loaded
// a finished block waits in the output register; the next transaction is taken
//   meanwhile and a later block waits at its end until the register is free
module idea_block_cipher_core (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // key_index [5:0], key_value [21:6], block_in [85:22], zero [87:86]
  input  logic [ibc_pkg::IN_TDATA_W-1:0]   in_tdata,
  // req_type [0]
  input  logic                             in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // block_out [63:0]
  output logic [ibc_pkg::BLOCK_W-1:0]      out_tdata
);

  import ibc_pkg::*;

  `include "idea_block_cipher_core_macros.svh"

  state_t              state_r, state_nxt;
  logic [STEP_W-1:0]   step_r, step_nxt;
  logic [RND_W-1:0]    rnd_r, rnd_nxt;
  logic [KEY_AW-1:0]   kptr_r, kptr_nxt;
  word_t               w0_r, w0_nxt, w1_r, w1_nxt, w2_r, w2_nxt, w3_r, w3_nxt;
  word_t               t_r, t_nxt, u_r, u_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [BLOCK_W-1:0]  out_data_r, out_data_nxt;

  logic [5:0]          in_key_index;
  word_t               in_key_value;
  logic [BLOCK_W-1:0]  in_block;
  logic                in_acc, blk_acc, load_acc, key_we;
  word_t               key_q, mul_a, mul_b, mul_res, mix_s;

  assign in_key_index = in_tdata[5:0];
  assign in_key_value = in_tdata[21:6];
  assign in_block     = in_tdata[85:22];

  assign in_acc   = in_tvalid && in_tready;
  assign blk_acc  = in_acc && (in_tuser == REQ_BLOCK);
  assign load_acc = in_acc && (in_tuser == REQ_LOAD);
  assign key_we   = load_acc && (in_key_index < 6'(KEY_DEPTH));

  ibc_ram #(
    .WIDTH (WORD_W),
    .DEPTH (KEY_DEPTH)
  ) u_key_ram (
    .clk   (clk),
    .we    (key_we),
    .waddr (in_key_index[KEY_AW-1:0]),
    .wdata (in_key_value),
    .raddr (kptr_nxt),
    .rdata (key_q)
  );

  // shared multiplier operand select
  always_comb begin
    mul_a = w0_r;
    mul_b = key_q;
    case (state_r)
      ST_ROUND: begin
        case (step_r)
          STEP_MUL3: mul_a = w3_r;
          STEP_MULT: mul_a = w0_r ^ w2_r;
          STEP_MULU: mul_a = (w1_r ^ w3_r) + t_r;
          default:   mul_a = w0_r;
        endcase
      end
      ST_FINAL: begin
        if (step_r == FIN_MUL3) begin
          mul_a = w3_r;
        end
      end
      default: mul_a = w0_r;
    endcase
  end

  assign mul_res = mulmod(mul_a, mul_b);
  assign mix_s   = t_r + u_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    rnd_nxt   = rnd_r;
    case (state_r)
      ST_IDLE: begin
        if (blk_acc) begin
          state_nxt = ST_ROUND;
          step_nxt  = STEP_MUL0;
          rnd_nxt   = '0;
        end
      end
      ST_ROUND: begin
        if (step_r == STEP_MIX) begin
          step_nxt = STEP_MUL0;
          if (rnd_r == RND_W'(ROUNDS - 1)) begin
            state_nxt = ST_FINAL;
          end else begin
            rnd_nxt = rnd_r + RND_W'(1);
          end
        end else begin
          step_nxt = step_r + STEP_W'(1);
        end
      end
      ST_FINAL: begin
        if (step_r == FIN_MUL3) begin
          state_nxt = ST_OUT;
          step_nxt  = STEP_MUL0;
        end else begin
          step_nxt = step_r + STEP_W'(1);
        end
      end
      ST_OUT: begin
        if (!out_valid_r || out_tready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs and datapath
  always_comb begin
    in_tready     = 1'b0;
    kptr_nxt      = kptr_r;
    w0_nxt        = w0_r;
    w1_nxt        = w1_r;
    w2_nxt        = w2_r;
    w3_nxt        = w3_r;
    t_nxt         = t_r;
    u_nxt         = u_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        kptr_nxt  = '0;
        if (blk_acc) begin
          w0_nxt = in_block[63:48];
          w1_nxt = in_block[47:32];
          w2_nxt = in_block[31:16];
          w3_nxt = in_block[15:0];
        end
      end
      ST_ROUND: begin
        case (step_r)
          STEP_MUL0: begin
            w0_nxt   = mul_res;
            kptr_nxt = kptr_r + KEY_AW'(1);
          end
          STEP_ADD1: begin
            w1_nxt   = w1_r + key_q;
            kptr_nxt = kptr_r + KEY_AW'(1);
          end
          STEP_ADD2: begin
            w2_nxt   = w2_r + key_q;
            kptr_nxt = kptr_r + KEY_AW'(1);
          end
          STEP_MUL3: begin
            w3_nxt   = mul_res;
            kptr_nxt = kptr_r + KEY_AW'(1);
          end
          STEP_MULT: begin
            t_nxt    = mul_res;
            kptr_nxt = kptr_r + KEY_AW'(1);
          end
          STEP_MULU: begin
            u_nxt    = mul_res;
            kptr_nxt = kptr_r + KEY_AW'(1);
          end
          STEP_MIX: begin
            w0_nxt = w0_r ^ u_r;
            w3_nxt = w3_r ^ mix_s;
            w1_nxt = w2_r ^ u_r;
            w2_nxt = w1_r ^ mix_s;
          end
          default: kptr_nxt = kptr_r;
        endcase
      end
      ST_FINAL: begin
        case (step_r)
          FIN_MUL0: begin
            w0_nxt   = mul_res;
            kptr_nxt = kptr_r + KEY_AW'(1);
          end
          FIN_ADD1: begin
            w2_nxt   = w2_r + key_q;
            kptr_nxt = kptr_r + KEY_AW'(1);
          end
          FIN_ADD2: begin
            w1_nxt   = w1_r + key_q;
            kptr_nxt = kptr_r + KEY_AW'(1);
          end
          FIN_MUL3: begin
            w3_nxt   = mul_res;
            kptr_nxt = '0;
          end
          default: kptr_nxt = kptr_r;
        endcase
      end
      ST_OUT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {w0_r, w2_r, w1_r, w3_r};
        end
      end
      default: kptr_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= STEP_MUL0;
      rnd_r       <= '0;
      kptr_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      rnd_r       <= rnd_nxt;
      kptr_r      <= kptr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    w0_r       <= w0_nxt;
    w1_r       <= w1_nxt;
    w2_r       <= w2_nxt;
    w3_r       <= w3_nxt;
    t_r        <= t_nxt;
    u_r        <= u_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  `IBC_ASSERT_NXT(a_block_start, blk_acc, (state_r == ST_ROUND) && (kptr_r == '0) && (rnd_r == '0))
  `IBC_ASSERT_IMP(a_step_range, state_r == ST_ROUND, step_r <= STEP_MIX)
  `IBC_ASSERT_NXT(a_mix_holds_ptr, (state_r == ST_ROUND) && (step_r == STEP_MIX), $stable(kptr_r))
  `IBC_ASSERT_IMP(a_final_keys, state_r == ST_FINAL, kptr_r >= KEY_AW'(6 * ROUNDS))
  `IBC_ASSERT_NXT(a_out_load, (state_r == ST_OUT) && (!out_valid_r || out_tready), out_tvalid)

endmodule

// ----- verif/idea_block_cipher_core_tb.sv -----
// self-checking testbench for the idea block cipher core: subkey loads and block transforms
`timescale 1ns / 1ps

module idea_block_cipher_core_tb;

  localparam int ITEM_TARGET = 650;
  localparam int HOLD_CYCLES = 300;
  localparam int TAIL_CYCLES = 80;
  localparam int QUIET_LIMIT = 4000;
  localparam longint unsigned FERMAT_PRIME = 65537;
  localparam longint unsigned ZERO_WORD_VALUE = 65536;

  typedef enum logic [1:0] {
    ROW_FILL,
    ROW_LOAD,
    ROW_BLOCK
  } row_kind_t;

  typedef struct packed {
    row_kind_t   kind;
    logic [5:0]  idx;
    logic [15:0] val;
    logic [63:0] blk;
  } dir_row_t;

  // fill rows write the whole subkey store with val, block rows carry ignored key fields
  localparam dir_row_t DIR_ROWS [20] = '{
    '{ROW_FILL,  6'd0,  16'h0000, 64'h0000_0000_0000_0000},
    '{ROW_BLOCK, 6'd0,  16'h0000, 64'h0000_0000_0000_0000},
    '{ROW_BLOCK, 6'd0,  16'h0000, 64'hFFFF_FFFF_FFFF_FFFF},
    '{ROW_BLOCK, 6'd63, 16'hFFFF, 64'h0000_FFFF_8000_0001},
    '{ROW_FILL,  6'd0,  16'hFFFF, 64'h0000_0000_0000_0000},
    '{ROW_BLOCK, 6'd0,  16'h0000, 64'h0000_0000_0000_0000},
    '{ROW_BLOCK, 6'd0,  16'h0000, 64'hFFFF_FFFF_FFFF_FFFF},
    '{ROW_FILL,  6'd0,  16'h0001, 64'h0000_0000_0000_0000},
    '{ROW_BLOCK, 6'd0,  16'h0000, 64'h0123_4567_89AB_CDEF},
    '{ROW_LOAD,  6'd52, 16'hFFFF, 64'hFFFF_FFFF_FFFF_FFFF},
    '{ROW_LOAD,  6'd63, 16'hABCD, 64'h0000_0000_0000_0000},
    '{ROW_BLOCK, 6'd0,  16'h0000, 64'h0123_4567_89AB_CDEF},
    '{ROW_LOAD,  6'd0,  16'h8000, 64'h0000_0000_0000_0000},
    '{ROW_LOAD,  6'd51, 16'hFFFF, 64'h0000_0000_0000_0000},
    '{ROW_LOAD,  6'd4,  16'h0000, 64'h0000_0000_0000_0000},
    '{ROW_BLOCK, 6'd0,  16'h0000, 64'h8000_8000_8000_8000},
    '{ROW_BLOCK, 6'd0,  16'h0000, 64'h0000_0001_0002_0003},
    '{ROW_FILL,  6'd0,  16'h8000, 64'h0000_0000_0000_0000},
    '{ROW_BLOCK, 6'd0,  16'h0000, 64'hFFFF_0000_FFFF_0000},
    '{ROW_BLOCK, 6'd0,  16'h0000, 64'h0001_0001_0001_0001}
  };

  logic                            clk        = 1'b0;
  logic                            rst_n      = 1'b0;
  logic                            in_tvalid  = 1'b0;
  logic                            in_tready;
  logic [ibc_pkg::IN_TDATA_W-1:0]  in_tdata   = '0;
  logic                            in_tuser   = ibc_pkg::REQ_LOAD;
  logic                            out_tvalid;
  logic                            out_tready = 1'b0;
  logic [ibc_pkg::BLOCK_W-1:0]     out_tdata;

  ibc_pkg::word_t subkey_mirror [ibc_pkg::KEY_DEPTH];
  logic [ibc_pkg::BLOCK_W-1:0] pending_blocks [$];

  int  mismatches     = 0;
  int  blocks_checked = 0;
  int  loads_sent     = 0;
  int  items_sent     = 0;
  int  fills_done     = 0;
  int  holds_asked    = 0;
  int  quiet_cycles   = 0;
  bit  no_idle        = 1'b0;

  idea_block_cipher_core u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // multiply mod 2^16+1 with the all-zero word standing for 2^16
  function automatic ibc_pkg::word_t mul_fermat(ibc_pkg::word_t a, ibc_pkg::word_t b);
    longint unsigned x;
    longint unsigned y;
    x = (a == '0) ? ZERO_WORD_VALUE : longint'(a);
    y = (b == '0) ? ZERO_WORD_VALUE : longint'(b);
    return ibc_pkg::word_t'((x * y) % FERMAT_PRIME);
  endfunction

  function automatic logic [ibc_pkg::BLOCK_W-1:0] idea_transform(
    logic [ibc_pkg::BLOCK_W-1:0] blk
  );
    ibc_pkg::word_t a, b, c, d, t, u, s, swap;
    int base;
    a = blk[63:48];
    b = blk[47:32];
    c = blk[31:16];
    d = blk[15:0];
    for (int r = 0; r < ibc_pkg::ROUNDS; r++) begin
      base = 6 * r;
      a = mul_fermat(a, subkey_mirror[base]);
      b = b + subkey_mirror[base + 1];
      c = c + subkey_mirror[base + 2];
      d = mul_fermat(d, subkey_mirror[base + 3]);
      t = mul_fermat(a ^ c, subkey_mirror[base + 4]);
      u = mul_fermat(ibc_pkg::word_t'((b ^ d) + t), subkey_mirror[base + 5]);
      s = t + u;
      a = a ^ u;
      d = d ^ s;
      swap = b ^ s;
      b = c ^ u;
      c = swap;
    end
    base = 6 * ibc_pkg::ROUNDS;
    return {mul_fermat(a, subkey_mirror[base]),
            ibc_pkg::word_t'(c + subkey_mirror[base + 1]),
            ibc_pkg::word_t'(b + subkey_mirror[base + 2]),
            mul_fermat(d, subkey_mirror[base + 3])};
  endfunction

  function automatic ibc_pkg::word_t rand_word();
    case ($urandom_range(0, 7))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'h0001;
      3: return 16'h8000;
      default: return ibc_pkg::word_t'($urandom);
    endcase
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $time);
    mismatches++;
  endtask

  task automatic send_item(logic req, logic [5:0] idx, logic [15:0] val, logic [63:0] blk);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 9);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= req;
    in_tdata  <= {2'b00, blk, val, idx};
    do @(posedge clk); while (!in_tready);
    if (req == ibc_pkg::REQ_BLOCK || idx < ibc_pkg::KEY_DEPTH) begin
      items_sent++;
    end
  endtask

  task automatic load_schedule(bit random_vals, logic [15:0] fill);
    for (int k = 0; k < ibc_pkg::KEY_DEPTH; k++) begin
      send_item(ibc_pkg::REQ_LOAD, 6'(k), random_vals ? rand_word() : fill,
                {$urandom, $urandom});
    end
    fills_done++;
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (pending_blocks.size() != 0) @(posedge clk);
  endtask

  // input transaction: update the subkey mirror or queue the predicted block
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) begin
      if (in_tuser == ibc_pkg::REQ_LOAD) begin
        loads_sent++;
        if (in_tdata[5:0] < ibc_pkg::KEY_DEPTH) begin
          subkey_mirror[in_tdata[5:0]] = in_tdata[21:6];
        end
      end else begin
        pending_blocks.push_back(idea_transform(in_tdata[85:22]));
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_blocks.size() == 0) begin
        report_mismatch("unexpected block", out_tdata, 'x);
      end else begin
        if (out_tdata !== pending_blocks[0]) begin
          report_mismatch("block_out", out_tdata, pending_blocks[0]);
        end
        void'(pending_blocks.pop_front());
        blocks_checked++;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles", QUIET_LIMIT);
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int unsigned stall;
    int          holds_done;
    holds_done = 0;
    wait (rst_n);
    forever begin
      if (holds_asked > holds_done) begin
        holds_done++;
        stall = HOLD_CYCLES;
      end else begin
        stall = no_idle ? 0 : $urandom_range(0, 9);
      end
      if (stall != 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  initial begin
    int step;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (DIR_ROWS[i]) begin
      case (DIR_ROWS[i].kind)
        ROW_FILL:  load_schedule(1'b0, DIR_ROWS[i].val);
        ROW_LOAD:  send_item(ibc_pkg::REQ_LOAD, DIR_ROWS[i].idx, DIR_ROWS[i].val,
                             DIR_ROWS[i].blk);
        default:   send_item(ibc_pkg::REQ_BLOCK, DIR_ROWS[i].idx, DIR_ROWS[i].val,
                             DIR_ROWS[i].blk);
      endcase
    end

    load_schedule(1'b1, '0);
    for (step = 0; items_sent < ITEM_TARGET; step++) begin
      no_idle = ((step / 40) % 3 == 2);
      if (step == 100) begin
        holds_asked++;
      end
      if (step == 200) begin
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
      end
      if (step % 150 == 149) begin
        load_schedule(1'b1, '0);
      end else if ($urandom_range(0, 99) < 12) begin
        send_item(ibc_pkg::REQ_LOAD, 6'($urandom_range(0, 63)), rand_word(),
                  {$urandom, $urandom});
      end else begin
        send_item(ibc_pkg::REQ_BLOCK, 6'($urandom_range(0, 63)), 16'($urandom),
                  {rand_word(), rand_word(), rand_word(), rand_word()});
      end
    end
    in_tvalid <= 1'b0;

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("covered %0d blocks checked, %0d subkey loads, %0d full schedules",
             blocks_checked, loads_sent, fills_done);
    $display("%0d mismatches", mismatches);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
